### rtl/dmssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmssp_pkg
// shared types, constants and the microcode store of the speed / steering pid
// ----------------------------------------------------------------------------
package dmssp_pkg;

  localparam int GAIN_W    = 16;
  localparam int SPEED_W   = 16;
  localparam int COL_W     = 8;
  localparam int SPD_ERR_W = 17;
  localparam int STR_ERR_W = 9;
  localparam int SLOPE_W   = 10;
  localparam int OPA_W     = 20;
  localparam int OPB_W     = 18;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int ACC_W     = 40;
  localparam int OUT_W     = 32;
  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic signed [SPD_ERR_W-1:0] SPEED_BIG_ERR  = 17'sd20;
  localparam logic signed [OPB_W-1:0]     STEER_LIN_COEF = 18'sd5;
  localparam logic signed [ACC_W-1:0]     STEER_OFFSET   = 40'sd3;
  localparam logic [COL_W-1:0]            VIEW_MID_RESET = 8'd64;

  typedef enum logic {
    OP_SPEED = 1'b0,
    OP_STEER = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SETPOINT  = 3'd0,
    REG_SPEED_GAIN_CUR  = 3'd1,
    REG_SPEED_GAIN_LAST = 3'd2,
    REG_SPEED_GAIN_OLD  = 3'd3,
    REG_STEER_KD        = 3'd4,
    REG_VIEW_MIDLINE    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    A_GAIN_CUR  = 3'd0,
    A_GAIN_LAST = 3'd1,
    A_GAIN_OLD  = 3'd2,
    A_STEER_KD  = 3'd3,
    A_SLOPE     = 3'd4,
    A_SLOPE_MAG = 3'd5,
    A_ACC       = 3'd6
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SPD_ERR  = 3'd0,
    B_SPD_LAST = 3'd1,
    B_SPD_OLD  = 3'd2,
    B_SLOPE    = 3'd3,
    B_LIN_COEF = 3'd4,
    B_STR_ERR  = 3'd5,
    B_STR_LAST = 3'd6
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD      = 2'd0,
    ACC_LOAD      = 2'd1,
    ACC_ADD       = 2'd2,
    ACC_ADD_SMALL = 2'd3
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    plus3;
    logic    commit;
  } ctrl_t;

  localparam logic [PC_W-1:0] SPEED_ENTRY = 4'd0;
  localparam logic [PC_W-1:0] STEER_ENTRY = 4'd5;
  localparam logic [PC_W-1:0] LAST_PC     = 4'd11;

  localparam ctrl_t CTRL_NOP = '{A_GAIN_CUR, B_SPD_ERR, ACC_HOLD, 1'b0, 1'b0};

  // microcode: the product of one step is accumulated in the next
  function automatic ctrl_t dmssp_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    begin
      w = CTRL_NOP;
      case (pc)
        // speed loop
        4'd0:  w = '{A_GAIN_CUR,  B_SPD_ERR,  ACC_HOLD,      1'b0, 1'b0};
        4'd1:  w = '{A_GAIN_LAST, B_SPD_LAST, ACC_LOAD,      1'b0, 1'b0};
        4'd2:  w = '{A_GAIN_OLD,  B_SPD_OLD,  ACC_ADD,       1'b0, 1'b0};
        4'd3:  w = '{A_GAIN_CUR,  B_SPD_ERR,  ACC_ADD_SMALL, 1'b0, 1'b0};
        4'd4:  w = '{A_GAIN_CUR,  B_SPD_ERR,  ACC_HOLD,      1'b0, 1'b1};
        // steering loop
        4'd5:  w = '{A_SLOPE,     B_SLOPE,    ACC_HOLD,      1'b0, 1'b0};
        4'd6:  w = '{A_SLOPE_MAG, B_LIN_COEF, ACC_LOAD,      1'b0, 1'b0};
        4'd7:  w = '{A_SLOPE,     B_SLOPE,    ACC_ADD,       1'b1, 1'b0};
        4'd8:  w = '{A_ACC,       B_STR_ERR,  ACC_HOLD,      1'b0, 1'b0};
        4'd9:  w = '{A_STEER_KD,  B_STR_LAST, ACC_LOAD,      1'b0, 1'b0};
        4'd10: w = '{A_STEER_KD,  B_STR_LAST, ACC_ADD,       1'b0, 1'b0};
        4'd11: w = '{A_STEER_KD,  B_STR_LAST, ACC_HOLD,      1'b0, 1'b1};
        default: w = CTRL_NOP;
      endcase
      return w;
    end
  endfunction

endpackage

### rtl/dmssp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmssp_datapath
// config registers, error history, shared multiplier, accumulator, saturation
// ----------------------------------------------------------------------------
module dmssp_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dmssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dmssp_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                              load,
  input  logic                              opcode,
  input  logic [dmssp_pkg::SPEED_W-1:0]     measured_speed,
  input  logic [dmssp_pkg::COL_W-1:0]       midline_col,
  input  dmssp_pkg::ctrl_t                  ctrl,
  input  logic                              commit,
  output logic [dmssp_pkg::OUT_W-1:0]       drive_value
);
  import dmssp_pkg::*;

  logic signed [GAIN_W-1:0]    setpoint_r, gain_cur_r, gain_last_r, gain_old_r, steer_kd_r;
  logic [COL_W-1:0]            view_mid_r;
  logic signed [SPD_ERR_W-1:0] spd_last_r, spd_old_r, spd_err_r;
  logic signed [STR_ERR_W-1:0] str_last_r, str_err_r;
  logic signed [SLOPE_W-1:0]   slope_r;
  opcode_t                     mode_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic [OUT_W-1:0]            out_r;

  logic signed [SPD_ERR_W-1:0] spd_err_nxt;
  logic signed [STR_ERR_W-1:0] str_err_nxt;
  logic signed [SLOPE_W-1:0]   slope_nxt;
  logic [SLOPE_W-1:0]          slope_mag;
  logic signed [OPA_W-1:0]     op_a;
  logic signed [OPB_W-1:0]     op_b;
  logic signed [ACC_W-1:0]     prod_ext, acc_nxt;
  logic                        small_err;
  logic [OUT_W-1:0]            sat_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= '0;
      gain_cur_r  <= '0;
      gain_last_r <= '0;
      gain_old_r  <= '0;
      steer_kd_r  <= '0;
      view_mid_r  <= VIEW_MID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_SETPOINT:  setpoint_r  <= cfg_data;
        REG_SPEED_GAIN_CUR:  gain_cur_r  <= cfg_data;
        REG_SPEED_GAIN_LAST: gain_last_r <= cfg_data;
        REG_SPEED_GAIN_OLD:  gain_old_r  <= cfg_data;
        REG_STEER_KD:        steer_kd_r  <= cfg_data;
        REG_VIEW_MIDLINE:    view_mid_r  <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  assign spd_err_nxt = {setpoint_r[GAIN_W-1], setpoint_r}
                     - {measured_speed[SPEED_W-1], measured_speed};
  assign str_err_nxt = {1'b0, midline_col} - {1'b0, view_mid_r};
  assign slope_nxt   = {str_err_nxt[STR_ERR_W-1], str_err_nxt}
                     - {str_last_r[STR_ERR_W-1], str_last_r};
  assign slope_mag   = slope_r[SLOPE_W-1] ? SLOPE_W'(-slope_r) : slope_r;
  assign small_err   = (spd_err_r <= SPEED_BIG_ERR) && (spd_err_r >= -SPEED_BIG_ERR);

  always_comb begin
    case (ctrl.a_sel)
      A_GAIN_CUR:  op_a = OPA_W'(gain_cur_r);
      A_GAIN_LAST: op_a = OPA_W'(gain_last_r);
      A_GAIN_OLD:  op_a = OPA_W'(gain_old_r);
      A_STEER_KD:  op_a = OPA_W'(steer_kd_r);
      A_SLOPE:     op_a = OPA_W'(slope_r);
      A_SLOPE_MAG: op_a = {{(OPA_W-SLOPE_W){1'b0}}, slope_mag};
      A_ACC:       op_a = acc_r[OPA_W-1:0];
      default:     op_a = '0;
    endcase
    case (ctrl.b_sel)
      B_SPD_ERR:  op_b = OPB_W'(spd_err_r);
      B_SPD_LAST: op_b = OPB_W'(spd_last_r);
      B_SPD_OLD:  op_b = OPB_W'(spd_old_r);
      B_SLOPE:    op_b = OPB_W'(slope_r);
      B_LIN_COEF: op_b = STEER_LIN_COEF;
      B_STR_ERR:  op_b = OPB_W'(str_err_r);
      B_STR_LAST: op_b = OPB_W'(str_last_r);
      default:    op_b = '0;
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    case (ctrl.acc_op)
      ACC_HOLD:      acc_nxt = acc_r;
      ACC_LOAD:      acc_nxt = prod_ext;
      ACC_ADD:       acc_nxt = acc_r + prod_ext + (ctrl.plus3 ? STEER_OFFSET : '0);
      ACC_ADD_SMALL: acc_nxt = small_err ? acc_r + prod_ext : acc_r;
      default:       acc_nxt = acc_r;
    endcase
  end

  // clamp to the signed 32-bit range
  always_comb begin
    if (&acc_r[ACC_W-1:OUT_W-1] || ~|acc_r[ACC_W-1:OUT_W-1])
      sat_val = acc_r[OUT_W-1:0];
    else if (acc_r[ACC_W-1])
      sat_val = {1'b1, {(OUT_W-1){1'b0}}};
    else
      sat_val = {1'b0, {(OUT_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_last_r <= '0;
      spd_old_r  <= '0;
      str_last_r <= '0;
    end else if (commit) begin
      if (mode_r == OP_STEER) begin
        str_last_r <= str_err_r;
      end else begin
        spd_old_r  <= spd_last_r;
        spd_last_r <= spd_err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
    if (load) begin
      mode_r    <= opcode_t'(opcode);
      spd_err_r <= spd_err_nxt;
      str_err_r <= str_err_nxt;
      slope_r   <= slope_nxt;
    end
    if (commit) begin
      out_r <= sat_val;
    end
  end

  assign drive_value = out_r;

endmodule

### rtl/dual_mode_speed_steer_pid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_speed_steer_pid_core
// speed / steering pid run by a microcoded step sequencer over one multiplier
// ----------------------------------------------------------------------------
// the microcode runs one item at a time through the single shared multiplier
//   and accumulator; the speed program is shorter than the steering one
// a new beat is taken once the sequencer is done, while the last result waits
// reset: synchronous active-low rst_n clears history, config and handshake
//   state; view midline resets to 64, other config registers to 0
// ----------------------------------------------------------------------------
module dual_mode_speed_steer_pid_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dmssp_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // measured_speed, midline_col
  input  logic [0:0]                        in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dmssp_pkg::OUT_W-1:0]       out_tdata   // drive_value
);
  import dmssp_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_fire, commit_fire;
  ctrl_t           rom_word, ctrl;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;

  assign rom_word    = dmssp_rom(pc_r);
  assign ctrl        = busy_r ? rom_word : CTRL_NOP;
  assign commit_fire = busy_r && rom_word.commit && (!out_valid_r || out_tready);

  always_comb begin
    pc_nxt = pc_r;
    if (in_fire)
      pc_nxt = (in_tuser[0] == OP_STEER) ? STEER_ENTRY : SPEED_ENTRY;
    else if (busy_r && !rom_word.commit)
      pc_nxt = pc_r + 1'b1;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire)
      busy_nxt = 1'b1;
    else if (commit_fire)
      busy_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_fire)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= SPEED_ENTRY;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  dmssp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .load           (in_fire),
    .opcode         (in_tuser[0]),
    .measured_speed (in_tdata[15:0]),
    .midline_col    (in_tdata[23:16]),
    .ctrl           (ctrl),
    .commit         (commit_fire),
    .drive_value    (out_tdata)
  );

  assign out_tvalid = out_valid_r;

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r && (pc_r == SPEED_ENTRY || pc_r == STEER_ENTRY))
    else $error("sequencer did not start at a program entry");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= LAST_PC)
    else $error("step counter left the program");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire |=> out_tvalid && !busy_r)
    else $error("finished item did not present a result");

endmodule
